>>> rtl/core/mipd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_pkg
// Shared types and constants for the mains input presence detector.
// ----------------------------------------------------------------------------
package mipd_pkg;

    // Channel count default and number of physical pins
    localparam int CHANNELS  = 8;
    localparam int PIN_COUNT = 8;

    // Field widths
    localparam int CNT_W  = 8;
    localparam int DEB_W  = 4;
    localparam int CFG_W  = 8;
    localparam int IDX_W  = 3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_WINDOW_TICKS  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SAMPLE_TICKS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_LOW_THRESHOLD = 3'd2;
    localparam logic [IDX_W-1:0] REG_TOGGLE_MODE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_CYCLES_ON     = 3'd4;
    localparam logic [IDX_W-1:0] REG_CYCLES_OFF    = 3'd5;

    // Register reset values
    localparam logic [CNT_W-1:0] WINDOW_TICKS_RST  = 8'd125;
    localparam logic [CNT_W-1:0] SAMPLE_TICKS_RST  = 8'd70;
    localparam logic [CNT_W-1:0] LOW_THRESHOLD_RST = 8'd40;
    localparam logic             TOGGLE_MODE_RST   = 1'b1;
    localparam logic [DEB_W-1:0] CYCLES_ON_RST     = 4'd1;
    localparam logic [DEB_W-1:0] CYCLES_OFF_RST    = 4'd1;

    // Judgement settings shared by all channels
    typedef struct packed {
        logic [CNT_W-1:0] low_threshold;
        logic             toggle_mode;
        logic [DEB_W-1:0] cycles_on;
        logic [DEB_W-1:0] cycles_off;
    } judge_cfg_t;

    // Per-tick window control for the channels
    typedef struct packed {
        logic count_en;
        logic judge_en;
        logic clear_en;
    } chan_ctrl_t;

endpackage

>>> rtl/core/mains_input_presence_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mains_input_presence_detector_unit
// Counts high pin samples per channel over a window of timer ticks, judges
// every channel once per window and debounces the result into output bits.
// ----------------------------------------------------------------------------
// Results are registered. Throughput: one tick per cycle while s_tready is
// high; all channels are judged in parallel in the cycle of the transfer,
// and a two-entry output buffer keeps s_tready high while one result waits
// and drops it when both are full. Synchronous active-low reset clears the
// window position, all channel state, output buffer; restores the registers.
// ----------------------------------------------------------------------------
module mains_input_presence_detector_unit #(
    parameter int CHANNELS = mipd_pkg::CHANNELS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [mipd_pkg::IDX_W-1:0]    cfg_index,
    input  logic [mipd_pkg::CFG_W-1:0]    cfg_data,
    // input ticks
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pin_levels
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] channel_outputs
    output logic                          m_tuser    // [0] evaluated
);

    localparam int REPORTED = (CHANNELS < 8) ? CHANNELS : 8;

    // Configuration registers
    logic [mipd_pkg::CNT_W-1:0] window_ticks_reg;
    logic [mipd_pkg::CNT_W-1:0] sample_ticks_reg;
    mipd_pkg::judge_cfg_t       judge_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_ticks_reg            <= mipd_pkg::WINDOW_TICKS_RST;
            sample_ticks_reg            <= mipd_pkg::SAMPLE_TICKS_RST;
            judge_cfg_reg.low_threshold <= mipd_pkg::LOW_THRESHOLD_RST;
            judge_cfg_reg.toggle_mode   <= mipd_pkg::TOGGLE_MODE_RST;
            judge_cfg_reg.cycles_on     <= mipd_pkg::CYCLES_ON_RST;
            judge_cfg_reg.cycles_off    <= mipd_pkg::CYCLES_OFF_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mipd_pkg::REG_WINDOW_TICKS:  window_ticks_reg <= cfg_data;
                mipd_pkg::REG_SAMPLE_TICKS:  sample_ticks_reg <= cfg_data;
                mipd_pkg::REG_LOW_THRESHOLD: judge_cfg_reg.low_threshold <= cfg_data;
                mipd_pkg::REG_TOGGLE_MODE:   judge_cfg_reg.toggle_mode <= cfg_data[0];
                mipd_pkg::REG_CYCLES_ON:
                    judge_cfg_reg.cycles_on <= cfg_data[mipd_pkg::DEB_W-1:0];
                mipd_pkg::REG_CYCLES_OFF:
                    judge_cfg_reg.cycles_off <= cfg_data[mipd_pkg::DEB_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake
    logic in_xfer, out_xfer;
    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic [7:0] main_data_reg, main_data_next, skid_data_reg, skid_data_next;
    logic main_eval_reg, main_eval_next, skid_eval_reg, skid_eval_next;

    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = main_valid_reg && m_tready;

    // Window position and per-tick control
    logic [mipd_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic [mipd_pkg::CNT_W-1:0] last_pos, judge_pos;
    mipd_pkg::chan_ctrl_t       ctrl;

    always_comb begin
        last_pos = (window_ticks_reg < 8'd2) ? '0 : window_ticks_reg - 1'b1;
        if (sample_ticks_reg == '0) begin
            judge_pos = '0;
        end else if (sample_ticks_reg < window_ticks_reg) begin
            judge_pos = sample_ticks_reg - 1'b1;
        end else begin
            judge_pos = last_pos;
        end
        ctrl.count_en = in_xfer && (pos_reg < sample_ticks_reg);
        ctrl.judge_en = in_xfer && (pos_reg == judge_pos);
        ctrl.clear_en = in_xfer && (pos_reg >= last_pos);
        if (!in_xfer) begin
            pos_next = pos_reg;
        end else if (pos_reg >= last_pos) begin
            pos_next = '0;
        end else begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // Channel array
    logic [CHANNELS-1:0] out_bits;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
        logic level;
        if (i < mipd_pkg::PIN_COUNT) begin : g_pin
            assign level = s_tdata[i];
        end else begin : g_nopin
            assign level = 1'b0;
        end
        mipd_channel u_chan (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cfg      (judge_cfg_reg),
            .ctrl     (ctrl),
            .level    (level),
            .out_next (out_bits[i])
        );
    end

    // Reported output bits, zero above the channel count
    logic [7:0] result_bits;

    always_comb begin
        result_bits = '0;
        result_bits[REPORTED-1:0] = out_bits[REPORTED-1:0];
    end

    // Two-entry output buffer
    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        main_eval_next  = main_eval_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_eval_next  = skid_eval_reg;
        if (out_xfer) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                main_eval_next  = skid_eval_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = 1'b0;
            end
        end
        if (in_xfer) begin
            if (!main_valid_next) begin
                main_valid_next = 1'b1;
                main_data_next  = result_bits;
                main_eval_next  = ctrl.judge_en;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result_bits;
                skid_eval_next  = ctrl.judge_en;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        main_eval_reg <= main_eval_next;
        skid_data_reg <= skid_data_next;
        skid_eval_reg <= skid_eval_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;
    assign m_tuser  = main_eval_reg;

endmodule

>>> rtl/core/mipd_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_channel
// One detector channel: high-sample counter, debounce counters, active flag
// and output bit. State moves only on ticks flagged by the control struct.
// ----------------------------------------------------------------------------
module mipd_channel (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mipd_pkg::judge_cfg_t  cfg,
    input  mipd_pkg::chan_ctrl_t  ctrl,
    input  logic                  level,
    output logic                  out_next
);

    logic [mipd_pkg::CNT_W-1:0] count_reg, count_next, count_inc;
    logic [mipd_pkg::DEB_W-1:0] up_reg, up_next, up_inc;
    logic [mipd_pkg::DEB_W-1:0] down_reg, down_next, down_inc;
    logic                       active_reg, active_next;
    logic                       out_reg;

    // Saturating high-sample count, including this tick
    always_comb begin
        count_inc = count_reg;
        if (ctrl.count_en && level && (count_reg != {mipd_pkg::CNT_W{1'b1}})) begin
            count_inc = count_reg + 1'b1;
        end
    end

    // Candidate debounce values when judged
    assign up_inc   = (up_reg < cfg.cycles_on)    ? up_reg + 1'b1   : up_reg;
    assign down_inc = (down_reg < cfg.cycles_off) ? down_reg + 1'b1 : down_reg;

    // Judgement and window clear
    always_comb begin
        up_next     = up_reg;
        down_next   = down_reg;
        active_next = active_reg;
        out_next    = out_reg;
        if (ctrl.judge_en) begin
            if (count_inc < cfg.low_threshold) begin
                down_next = '0;
                up_next   = up_inc;
                if ((up_inc >= cfg.cycles_on) && !active_reg) begin
                    active_next = 1'b1;
                    out_next    = cfg.toggle_mode ? ~out_reg : 1'b1;
                end
            end else begin
                up_next   = '0;
                down_next = down_inc;
                if ((down_inc >= cfg.cycles_off) && active_reg) begin
                    active_next = 1'b0;
                    if (!cfg.toggle_mode) begin
                        out_next = 1'b0;
                    end
                end
            end
        end
        count_next = ctrl.clear_en ? '0 : count_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            up_reg     <= '0;
            down_reg   <= '0;
            active_reg <= 1'b0;
            out_reg    <= 1'b0;
        end else begin
            count_reg  <= count_next;
            up_reg     <= up_next;
            down_reg   <= down_next;
            active_reg <= active_next;
            out_reg    <= out_next;
        end
    end

endmodule

>>> tb/sv/tb_mains_input_presence_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mains_input_presence_detector_unit
// Self-checking bench for the mains input presence detector. A behavioral
// copy of the window counter, per-channel high counts and debounce logic
// predicts channel outputs and the evaluated flag for every tick transfer.
// A short directed pass covers degenerate windows, zero sample ticks,
// register masking and a window cut short; random phases then sweep
// register settings with bursty ticks and an irregular result sink.
// ----------------------------------------------------------------------------
module tb_mains_input_presence_detector_unit;
    import mipd_pkg::*;

    localparam int RANDOM_TICKS = 1050;

    // unused register slots, writes there must not change anything
    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [7:0] channel_outputs;
        logic       evaluated;
    } tick_result_t;

    // result sink patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_QUARTER,
        RX_LONG_STALL
    } rx_pattern_e;

    // ------------------------------------------------------------------------
    // Behavioral copy of the detector plus queue of expected results
    // ------------------------------------------------------------------------
    class presence_model;
        logic [CNT_W-1:0]    window_len;
        logic [CNT_W-1:0]    sample_len;
        judge_cfg_t          judge;
        logic [CNT_W-1:0]    position;
        logic [CNT_W-1:0]    high_cnt [PIN_COUNT];
        logic [DEB_W-1:0]    up_cnt   [PIN_COUNT];
        logic [DEB_W-1:0]    down_cnt [PIN_COUNT];
        logic [PIN_COUNT-1:0] active;
        logic [PIN_COUNT-1:0] out_bits;
        tick_result_t        pending_results[$];
        int                  failures;
        int                  results_seen;

        function new();
            window_len          = WINDOW_TICKS_RST;
            sample_len          = SAMPLE_TICKS_RST;
            judge.low_threshold = LOW_THRESHOLD_RST;
            judge.toggle_mode   = TOGGLE_MODE_RST;
            judge.cycles_on     = CYCLES_ON_RST;
            judge.cycles_off    = CYCLES_OFF_RST;
            position            = '0;
            active              = '0;
            out_bits            = '0;
            foreach (high_cnt[i]) begin
                high_cnt[i] = '0;
                up_cnt[i]   = '0;
                down_cnt[i] = '0;
            end
            failures     = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_WINDOW_TICKS:  window_len          = value;
                REG_SAMPLE_TICKS:  sample_len          = value;
                REG_LOW_THRESHOLD: judge.low_threshold = value;
                REG_TOGGLE_MODE:   judge.toggle_mode   = value[0];
                REG_CYCLES_ON:     judge.cycles_on     = value[DEB_W-1:0];
                REG_CYCLES_OFF:    judge.cycles_off    = value[DEB_W-1:0];
                default: ;
            endcase
        endfunction

        // once-per-window verdict with saturating debounce
        function void judge_channel(int ch);
            if (high_cnt[ch] < judge.low_threshold) begin
                down_cnt[ch] = '0;
                if (up_cnt[ch] < judge.cycles_on) begin
                    up_cnt[ch] = up_cnt[ch] + 1'b1;
                end
                if (up_cnt[ch] >= judge.cycles_on && !active[ch]) begin
                    active[ch] = 1'b1;
                    if (judge.toggle_mode) begin
                        out_bits[ch] = ~out_bits[ch];
                    end else begin
                        out_bits[ch] = 1'b1;
                    end
                end
            end else begin
                up_cnt[ch] = '0;
                if (down_cnt[ch] < judge.cycles_off) begin
                    down_cnt[ch] = down_cnt[ch] + 1'b1;
                end
                if (down_cnt[ch] >= judge.cycles_off && active[ch]) begin
                    active[ch] = 1'b0;
                    if (!judge.toggle_mode) begin
                        out_bits[ch] = 1'b0;
                    end
                end
            end
        endfunction

        // advance one tick and queue the result it produces
        function void note_tick(logic [7:0] pins);
            int unsigned  last_pos;
            int unsigned  judge_pos;
            tick_result_t res;
            last_pos = (window_len < 2) ? 0 : int'(window_len) - 1;
            if (sample_len == 0) begin
                judge_pos = 0;
            end else if (sample_len < window_len) begin
                judge_pos = int'(sample_len) - 1;
            end else begin
                judge_pos = last_pos;
            end

            if (position < sample_len) begin
                for (int ch = 0; ch < PIN_COUNT; ch++) begin
                    if (pins[ch] && high_cnt[ch] != 8'hFF) begin
                        high_cnt[ch] = high_cnt[ch] + 1'b1;
                    end
                end
            end

            res.evaluated = (position == judge_pos);
            if (res.evaluated) begin
                for (int ch = 0; ch < PIN_COUNT; ch++) begin
                    judge_channel(ch);
                end
            end

            // window end clears position and counts
            if (position >= last_pos) begin
                position = '0;
                foreach (high_cnt[i]) high_cnt[i] = '0;
            end else begin
                position = position + 1'b1;
            end

            res.channel_outputs = out_bits;
            pending_results.push_back(res);
        endfunction

        function void check_outputs(logic [7:0] outs, logic evaluated);
            tick_result_t want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d with no tick pending: outputs %02h evaluated %0b",
                                 results_seen, outs, evaluated));
                return;
            end
            want = pending_results.pop_front();
            if (outs !== want.channel_outputs) begin
                report($sformatf("result %0d channel_outputs: expected %02h, got %02h",
                                 results_seen, want.channel_outputs, outs));
            end
            if (evaluated !== want.evaluated) begin
                report($sformatf("result %0d evaluated: expected %0b, got %0b",
                                 results_seen, want.evaluated, evaluated));
            end
        endfunction

        function void flush_leftover();
            while (pending_results.size() != 0) begin
                void'(pending_results.pop_front());
                report("expected result never arrived");
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;   // [7:0] pin_levels
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;          // [7:0] channel_outputs
    logic              m_tuser;          // [0] evaluated

    presence_model     model;
    int unsigned       duty [PIN_COUNT];
    rx_pattern_e       rx_pattern = RX_OPEN;
    int                rx_left    = 0;
    int                rx_cycle   = 0;

    mains_input_presence_detector_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // sample both streams; note the tick before checking results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                model.note_tick(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                model.check_outputs(m_tdata, m_tuser);
            end
        end
    end

    // result sink: switches between open, coin-flip, 1-in-4 and long stalls
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_pattern = rx_pattern_e'($urandom_range(3));
            rx_left    = $urandom_range(40, 300);
        end else begin
            rx_left--;
        end
        rx_cycle++;
        case (rx_pattern)
            RX_OPEN:    m_tready <= 1'b1;
            RX_COIN:    m_tready <= ($urandom_range(1) != 0);
            RX_QUARTER: m_tready <= (rx_cycle % 4 == 0);
            default:    m_tready <= (rx_cycle % 13 >= 9);
        endcase
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_tick(input logic [7:0] pins);
        s_tvalid <= 1'b1;
        s_tdata  <= pins;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop ticks and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (model.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        model.write_reg(idx, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // bursty ticks; per-channel duty mostly held across windows
    task automatic run_ticks(input int count, input int win, input bit pause_mid);
        int         sent;
        int         burst_left;
        int         gap;
        logic [7:0] pins;
        sent       = 0;
        burst_left = $urandom_range(1, 32);
        if (win < 1) win = 1;
        while (sent < count) begin
            if (sent % win == 0) begin
                foreach (duty[ch]) begin
                    if (sent == 0 || $urandom_range(9) < 3) begin
                        duty[ch] = $urandom_range(5) * 20;
                    end
                end
            end
            for (int ch = 0; ch < 8; ch++) begin
                pins[ch] = ($urandom_range(99) < duty[ch]);
            end
            send_tick(pins);
            sent++;
            burst_left--;
            if (pause_mid && sent == count / 2) begin
                drain_results();
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 32);
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int         phase;
        int         done_ticks;
        int         kind;
        int         count;
        int         win;
        int         samp;
        int         span;
        int         thr;
        int         c_on;
        int         c_off;
        logic [7:0] cfg_val;

        model = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, all-low, all-high and alternating pins
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'h55);
        send_tick(8'hAA);
        drain_results();

        // window shortened behind the position: ends now, no verdict
        set_reg(REG_WINDOW_TICKS, 8'd3);
        send_tick(8'h0F);
        send_tick(8'hF0);
        drain_results();

        // zero window, zero sample ticks, zero debounce; upper data bits dropped
        set_reg(REG_WINDOW_TICKS, 8'd0);
        set_reg(REG_SAMPLE_TICKS, 8'd0);
        set_reg(REG_LOW_THRESHOLD, 8'd1);
        set_reg(REG_TOGGLE_MODE, 8'hFE);
        set_reg(REG_CYCLES_ON, 8'hF0);
        set_reg(REG_CYCLES_OFF, 8'h10);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'h81);
        send_tick(8'h7E);
        drain_results();
        set_reg(REG_LOW_THRESHOLD, 8'd0);
        send_tick(8'hFF);
        send_tick(8'h00);
        drain_results();

        // one-tick window with sampling longer than the window, toggle mode
        set_reg(REG_WINDOW_TICKS, 8'd1);
        set_reg(REG_SAMPLE_TICKS, 8'd5);
        set_reg(REG_LOW_THRESHOLD, 8'd1);
        set_reg(REG_TOGGLE_MODE, 8'h01);
        set_reg(REG_CYCLES_ON, 8'h01);
        set_reg(REG_CYCLES_OFF, 8'h01);
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'hC3);
        drain_results();

        // unused register slots are ignored
        set_reg(REG_SPARE_A, 8'h01);
        set_reg(REG_SPARE_B, 8'hFF);

        // shortest real window, one sample tick, top threshold
        set_reg(REG_WINDOW_TICKS, 8'd2);
        set_reg(REG_SAMPLE_TICKS, 8'd1);
        set_reg(REG_LOW_THRESHOLD, 8'd255);
        send_tick(8'hFF);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'hA5);

        // random phases
        phase      = 0;
        done_ticks = 0;
        while (done_ticks < RANDOM_TICKS) begin
            kind = $urandom_range(7);
            if (phase == 0) begin
                // largest window, every tick sampled
                win   = 255;
                samp  = 255;
                thr   = 255;
                c_on  = 15;
                c_off = 15;
                count = 260;
            end else if (phase == 1) begin
                // power-on settings
                win   = WINDOW_TICKS_RST;
                samp  = SAMPLE_TICKS_RST;
                thr   = LOW_THRESHOLD_RST;
                c_on  = CYCLES_ON_RST;
                c_off = CYCLES_OFF_RST;
                count = 130;
            end else begin
                win = (kind == 4) ? $urandom_range(1) : $urandom_range(2, 16);
                if (win < 2) begin
                    samp = $urandom_range(255);
                end else if (kind == 0) begin
                    samp = 0;
                end else if (kind == 1) begin
                    samp = $urandom_range(win, 255);
                end else begin
                    samp = $urandom_range(1, win - 1);
                end
                span = (samp < win) ? samp : ((win < 1) ? 1 : win);
                if (kind == 2) begin
                    thr = 0;
                end else if (kind == 3) begin
                    thr = 255;
                end else begin
                    thr = $urandom_range(0, span + 1);
                end
                c_on  = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
                c_off = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
                count = $urandom_range(40, 100);
            end

            drain_results();
            set_reg(REG_WINDOW_TICKS, win[7:0]);
            set_reg(REG_SAMPLE_TICKS, samp[7:0]);
            set_reg(REG_LOW_THRESHOLD, thr[7:0]);
            cfg_val = 8'($urandom_range(255));
            if (phase == 0) begin
                cfg_val[0] = 1'b0;
            end else if (phase == 1) begin
                cfg_val[0] = TOGGLE_MODE_RST;
            end else begin
                cfg_val[0] = ($urandom_range(1) != 0);
            end
            set_reg(REG_TOGGLE_MODE, cfg_val);
            cfg_val      = 8'($urandom_range(255));
            cfg_val[3:0] = c_on[3:0];
            set_reg(REG_CYCLES_ON, cfg_val);
            cfg_val      = 8'($urandom_range(255));
            cfg_val[3:0] = c_off[3:0];
            set_reg(REG_CYCLES_OFF, cfg_val);
            if ($urandom_range(7) == 0) begin
                set_reg(($urandom_range(1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                        8'($urandom_range(255)));
            end

            run_ticks(count, win, (phase == 2) || ($urandom_range(2) == 0));
            done_ticks += count;
            phase++;
        end

        drain_results();
        repeat (10) @(posedge aclk);
        model.flush_leftover();
        if (model.failures == 0) begin
            $display("tb_mains_input_presence_detector_unit: PASS");
        end else begin
            $display("tb_mains_input_presence_detector_unit: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb_mains_input_presence_detector_unit: FAIL");
        $finish;
    end

endmodule
